FILE: rtl/boxf_pkg.sv
`timescale 1ns / 1ps
// boxf_pkg: shared widths, constants and types of the 3x3 box filter
// no dependencies; imported by every other file of the block but boxf_ram

package boxf_pkg;

    localparam int CFG_W       = 12;
    localparam int ROW_W       = 12;
    localparam int COL_OUT_W   = 11;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int COL_SUM_W   = 10;
    localparam int SUM_W       = 12;
    localparam int DIV9_MULT_W = 13;
    localparam int PROD_W      = SUM_W + DIV9_MULT_W;
    localparam int DIV9_SHIFT  = 16;

    // floor(x / 9) == (x * 7282) >> 16 for every 12-bit x
    localparam logic [DIV9_MULT_W-1:0] DIV9_MULT = 13'd7282;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    typedef enum logic [0:0]
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // channel 0 blue, 1 green, 2 red
    typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

    typedef struct packed
    {
        logic interior;
        logic border;
    } flags_t;

    typedef struct packed
    {
        logic load;
        logic interior;
        logic border;
    } merge_ctl_t;

endpackage

FILE: rtl/boxf_channels.sv
`timescale 1ns / 1ps
// boxf_pix_if and boxf_res_if: valid/ready channels for pixels and results
// depends on boxf_pkg

interface boxf_pix_if;
    import boxf_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface boxf_res_if;
    import boxf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_column;
    logic [CH_W-1:0]      out_blue;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_red;
    logic                 last_of_run;

    modport source (output valid, output out_row, output out_column, output out_blue,
                    output out_green, output out_red, output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_column, input out_blue,
                    input out_green, input out_red, input last_of_run, output ready);
endinterface

FILE: rtl/box_filter_3x3_rgb.sv
`timescale 1ns / 1ps
// box_filter_3x3_rgb: streaming 3x3 mean filter on 8-bit rgb pixels
// depends on boxf_pkg, boxf_channels, boxf_ram, boxf_lane, boxf_merge
//
//  port    | dir | carries                                   | request when
//  pixel   | in  | blue, green, red                          | valid && ready
//  result  | out | row, column, blue, green, red, last flag  | valid && ready
//  cfg     | in  | index, 12-bit data                        | cfg_wr_en
//
// one pixel per clock unless stalled; a two-result pixel holds stage 3 until both are sent
// path of a pixel to its first result: line store read, column sums, divide, output
// the single-port-pair line store read per pixel sets the one-pixel-per-cycle rate
// reset clears position and pipeline valids; line stores are not cleared
// a stalled result holds stage 3 if it has results, and full stages behind; empty stages fill

module box_filter_3x3_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  boxf_pkg::cfg_reg_t     cfg_index,
    input  logic [boxf_pkg::CFG_W-1:0] cfg_data,
    boxf_pix_if.sink               pixel,
    boxf_res_if.source             result
);
    import boxf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int LW = 2 * NUM_CH * CH_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [EW-1:0]    w_ext;
    logic [EW-1:0]    w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [AW-1:0]    c0;
    logic [ROW_W:0]   r0w;
    logic [ROW_W-1:0] r0;
    logic [EW-1:0]    c1;
    logic [ROW_W:0]   r1;
    logic             undersized;
    flags_t           flags;

    logic             ld1;
    logic             ld2;
    logic             ld3;
    logic             accept;
    logic             wr_en;
    logic             s3_needs;
    logic             busy;
    merge_ctl_t       mctl;

    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [AW-1:0]    s1_col_reg;
    rgb_t             s1_px_reg;
    flags_t           s1_flags_reg;
    logic             s2_valid_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [AW-1:0]    s2_col_reg;
    rgb_t             s2_px_reg;
    flags_t           s2_flags_reg;
    logic             s3_valid_reg;
    logic [ROW_W-1:0] s3_row_reg;
    logic [AW-1:0]    s3_col_reg;
    rgb_t             s3_px_reg;
    flags_t           s3_flags_reg;

    logic [LW-1:0]    ram_q;
    logic             byp_reg;
    logic             byp_next;
    logic [LW-1:0]    byp_data_reg;
    logic [LW-1:0]    above;
    rgb_t             above2;
    rgb_t             above1;
    rgb_t             px_in;
    rgb_t             mean;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // effective dimensions, position and flags of the incoming pixel, and the position after it
    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext == '0)
        begin
            w_eff = EW'(1);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        h_eff = (height_reg == '0) ? CFG_W'(1) : height_reg;

        if (EW'(col_reg) >= w_eff)
        begin
            c0  = '0;
            r0w = {1'b0, row_reg} + (ROW_W + 1)'(1);
        end
        else
        begin
            c0  = col_reg;
            r0w = {1'b0, row_reg};
        end
        if (r0w >= {1'b0, h_eff})
        begin
            r0w = '0;
        end
        r0 = r0w[ROW_W-1:0];

        c1 = EW'(c0) + EW'(1);
        r1 = {1'b0, r0};
        if (c1 >= w_eff)
        begin
            c1 = '0;
            r1 = r1 + (ROW_W + 1)'(1);
            if (r1 >= {1'b0, h_eff})
            begin
                r1 = '0;
            end
        end
        col_next = c1[AW-1:0];
        row_next = r1[ROW_W-1:0];

        undersized     = (w_eff < EW'(3)) || (h_eff < CFG_W'(3));
        flags.interior = !undersized && (r0 >= ROW_W'(2)) && (c0 >= AW'(2));
        flags.border   = undersized || (r0 == '0) || (c0 == '0) ||
                         (r0 == h_eff - CFG_W'(1)) || (EW'(c0) == w_eff - EW'(1));
    end

    // pipeline flow, stages fill bubbles while the output stalls
    assign s3_needs    = s3_flags_reg.interior || s3_flags_reg.border;
    assign ld3         = !s3_valid_reg || !s3_needs || !busy;
    assign ld2         = !s2_valid_reg || ld3;
    assign ld1         = !s1_valid_reg || ld2;
    assign pixel.ready = ld1;
    assign accept      = pixel.valid && ld1;
    assign wr_en       = s1_valid_reg && ld2;

    assign mctl.load     = s3_valid_reg && s3_needs && !busy;
    assign mctl.interior = s3_flags_reg.interior;
    assign mctl.border   = s3_flags_reg.border;

    assign px_in[0] = pixel.blue;
    assign px_in[1] = pixel.green;
    assign px_in[2] = pixel.red;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                byp_reg <= byp_next;
            end
            if (ld1)
            begin
                s1_valid_reg <= pixel.valid;
            end
            if (ld2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ld3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg   <= r0;
            s1_col_reg   <= c0;
            s1_px_reg    <= px_in;
            s1_flags_reg <= flags;
            byp_data_reg <= {above1, s1_px_reg};
        end
        if (ld2)
        begin
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_px_reg    <= s1_px_reg;
            s2_flags_reg <= s1_flags_reg;
        end
        if (ld3)
        begin
            s3_row_reg   <= s2_row_reg;
            s3_col_reg   <= s2_col_reg;
            s3_px_reg    <= s2_px_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // line stores: upper half two rows above, lower half one row above
    assign byp_next = wr_en && (s1_col_reg == c0);
    assign above    = byp_reg ? byp_data_reg : ram_q;
    assign above2   = above[LW-1 -: LW/2];
    assign above1   = above[LW/2-1:0];

    boxf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_col_reg),
        .wdata ({above1, s1_px_reg}),
        .re    (accept),
        .raddr (c0),
        .rdata (ram_q)
    );

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        boxf_lane u_lane (
            .clk      (clk),
            .shift_en (wr_en),
            .sum_en   (ld2),
            .quo_en   (ld3),
            .top      (above2[i]),
            .mid      (above1[i]),
            .cur      (s1_px_reg[i]),
            .quo      (mean[i])
        );
    end

    boxf_merge #(
        .AW (AW)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .row   (s3_row_reg),
        .col   (s3_col_reg),
        .px    (s3_px_reg),
        .mean  (mean),
        .busy  (busy),
        .res   (result)
    );

endmodule

FILE: rtl/boxf_ram.sv
`timescale 1ns / 1ps
// boxf_ram: generic single-write, single-read memory with registered read
// no dependencies

module boxf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/boxf_lane.sv
`timescale 1ns / 1ps
// boxf_lane: one color channel of the 3x3 mean, column sums and divide by 9
// depends on boxf_pkg

module boxf_lane (
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic                  sum_en,
    input  logic                  quo_en,
    input  logic [boxf_pkg::CH_W-1:0] top,
    input  logic [boxf_pkg::CH_W-1:0] mid,
    input  logic [boxf_pkg::CH_W-1:0] cur,
    output logic [boxf_pkg::CH_W-1:0] quo
);
    import boxf_pkg::*;

    logic [COL_SUM_W-1:0] col_sum;
    logic [SUM_W-1:0]     total;
    logic [COL_SUM_W-1:0] cs2_reg;
    logic [COL_SUM_W-1:0] cs1_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [PROD_W-1:0]    prod;
    logic [CH_W-1:0]      quo_reg;

    assign col_sum = COL_SUM_W'(top) + COL_SUM_W'(mid) + COL_SUM_W'(cur);
    assign total   = SUM_W'(cs2_reg) + SUM_W'(cs1_reg) + SUM_W'(col_sum);
    assign prod    = PROD_W'(sum_reg) * PROD_W'(DIV9_MULT);

    always_ff @(posedge clk)
    begin
        // window of the two previous columns
        if (shift_en)
        begin
            cs2_reg <= cs1_reg;
            cs1_reg <= col_sum;
        end
        if (sum_en)
        begin
            sum_reg <= total;
        end
        if (quo_en)
        begin
            quo_reg <= prod[DIV9_SHIFT +: CH_W];
        end
    end

    assign quo = quo_reg;

endmodule

FILE: rtl/boxf_merge.sv
`timescale 1ns / 1ps
// boxf_merge: output register, joins lane means with pass-through pixels
// depends on boxf_pkg and boxf_res_if

module boxf_merge #(
    parameter int AW = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  boxf_pkg::merge_ctl_t    ctl,
    input  logic [boxf_pkg::ROW_W-1:0] row,
    input  logic [AW-1:0]           col,
    input  boxf_pkg::rgb_t          px,
    input  boxf_pkg::rgb_t          mean,
    output logic                    busy,
    boxf_res_if.source              res
);
    import boxf_pkg::*;

    logic             int_pend_reg;
    logic             bor_pend_reg;
    logic [ROW_W-1:0] row_reg;
    logic [AW-1:0]    col_reg;
    rgb_t             px_reg;
    rgb_t             mean_reg;
    logic             last;
    logic             sent;
    rgb_t             sel;

    assign last = !(int_pend_reg && bor_pend_reg);
    assign sent = res.valid && res.ready;
    assign busy = res.valid && !(res.ready && last);
    assign sel  = int_pend_reg ? mean_reg : px_reg;

    assign res.valid       = int_pend_reg || bor_pend_reg;
    assign res.out_row     = int_pend_reg ? ROW_W'(row_reg - 1'b1) : row_reg;
    assign res.out_column  = int_pend_reg ? COL_OUT_W'(col_reg - 1'b1) : COL_OUT_W'(col_reg);
    assign res.out_blue    = sel[0];
    assign res.out_green   = sel[1];
    assign res.out_red     = sel[2];
    assign res.last_of_run = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_pend_reg <= 1'b0;
            bor_pend_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            int_pend_reg <= ctl.interior;
            bor_pend_reg <= ctl.border;
        end
        else if (sent)
        begin
            // interior mean goes first, then the border pass-through
            if (int_pend_reg)
            begin
                int_pend_reg <= 1'b0;
            end
            else
            begin
                bor_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            row_reg  <= row;
            col_reg  <= col;
            px_reg   <= px;
            mean_reg <= mean;
        end
    end

endmodule

FILE: rtl/boxf_checker.sv
`timescale 1ns / 1ps
// boxf_checker: port-level assertions on the result channel of the filter
// depends on boxf_pkg; bound to box_filter_3x3_rgb

module boxf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [boxf_pkg::ROW_W-1:0]     res_row,
    input logic [boxf_pkg::COL_OUT_W-1:0] res_column,
    input logic [boxf_pkg::CH_W-1:0]      res_blue,
    input logic [boxf_pkg::CH_W-1:0]      res_green,
    input logic [boxf_pkg::CH_W-1:0]      res_red,
    input logic                          res_last
);
    import boxf_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_row) && $stable(res_column) &&
        $stable(res_blue) && $stable(res_green) && $stable(res_red) && $stable(res_last))
        else $error("result changed while stalled");

    // a mean that is not last is followed at once by its border pixel
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid)
        else $error("second result of a pixel missing");

    // the border pixel sits one row and one column past the mean before it
    a_pair_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=>
        (res_row == ROW_W'($past(res_row) + 1'b1)) &&
        (res_column == COL_OUT_W'($past(res_column) + 1'b1)))
        else $error("second result at wrong position");

    // a mean that is not last is never reported on the top row or left column
    a_mean_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> (res_row != '0) && (res_column != '0))
        else $error("mean reported on border");

endmodule

bind box_filter_3x3_rgb boxf_checker u_boxf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_row    (result.out_row),
    .res_column (result.out_column),
    .res_blue   (result.out_blue),
    .res_green  (result.out_green),
    .res_red    (result.out_red),
    .res_last   (result.last_of_run)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for box_filter_3x3_rgb, whole frames of random and edge pixels
// predicts each 3x3 mean or pass-through pixel in step with accepted requests, checks in order
// depends on boxf_pkg, boxf_channels and the rtl of the block

module testbench;
    import boxf_pkg::*;

    localparam int LINE_DEPTH   = 2048;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTED = 10;

    typedef struct packed
    {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] column;
        logic [CH_W-1:0]      blue;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      red;
        logic                 last;
    } filtered_px_t;

    typedef enum
    {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_FLAT,
        FILL_BRIGHT
    } fill_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    cfg_reg_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    boxf_pix_if pixel_ch ();
    boxf_res_if result_ch ();

    box_filter_3x3_rgb #(
        .MAX_WIDTH(LINE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pixel_ch),
        .result(result_ch)
    );

    // filter state as seen from outside
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    rgb_t             rows_above2 [LINE_DEPTH] = '{default: '0};
    rgb_t             rows_above1 [LINE_DEPTH] = '{default: '0};
    rgb_t             window_cols [6] = '{default: '0};
    logic [11:0]      next_row = '0;
    logic [11:0]      next_col = '0;

    filtered_px_t pending_results [$];

    int          mismatches;
    int unsigned pixels_sent;
    int unsigned cycle_count;
    int          pix_gap_pct;
    int          res_stall_pct;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > LINE_DEPTH)
            return LINE_DEPTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic void predict_filter(input rgb_t px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        int unsigned  sum;
        bit           tiny;
        rgb_t         mean;
        rgb_t         col_now [3];
        filtered_px_t fresh [$];
        filtered_px_t item;
        w = eff_width();
        h = eff_height();
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h)
            next_row = 0;
        r = next_row;
        c = next_col;
        col_now[0] = rows_above2[c];
        col_now[1] = rows_above1[c];
        col_now[2] = px;
        rows_above2[c] = col_now[1];
        rows_above1[c] = px;
        tiny = (w < 3) || (h < 3);
        if (!tiny && r >= 2 && c >= 2)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                sum = 0;
                for (int i = 0; i < 6; i++)
                    sum += window_cols[i][ch];
                for (int i = 0; i < 3; i++)
                    sum += col_now[i][ch];
                mean[ch] = CH_W'(sum / 9);
            end
            item = '{ROW_W'(r - 1), COL_OUT_W'(c - 1), mean[0], mean[1], mean[2], 1'b0};
            fresh.push_back(item);
        end
        if (tiny || r == 0 || c == 0 || r == h - 1 || c == w - 1)
        begin
            item = '{ROW_W'(r), COL_OUT_W'(c), px[0], px[1], px[2], 1'b0};
            fresh.push_back(item);
        end
        for (int i = 0; i < 3; i++)
        begin
            window_cols[i] = window_cols[i + 3];
            window_cols[i + 3] = col_now[i];
        end
        next_col++;
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
            if (next_row >= h)
                next_row = 0;
        end
        if (fresh.size() != 0)
            fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i])
            pending_results.push_back(fresh[i]);
    endfunction

    function automatic string show(input filtered_px_t p);
        return $sformatf("row %0d col %0d bgr %0d/%0d/%0d last %0b",
                         p.row, p.column, p.blue, p.green, p.red, p.last);
    endfunction

    // requests in, results checked against the oldest prediction
    always @(posedge clk)
    begin
        filtered_px_t got;
        filtered_px_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
            predict_filter({pixel_ch.red, pixel_ch.green, pixel_ch.blue});
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.out_row, result_ch.out_column, result_ch.out_blue,
                    result_ch.out_green, result_ch.out_red, result_ch.last_of_run};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected result: %s", show(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("mismatch: expected %s, got %s", show(want), show(got));
                end
            end
        end
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= res_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_pixel(input rgb_t px);
        while ($urandom_range(99) < pix_gap_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.blue  <= px[0];
        pixel_ch.green <= px[1];
        pixel_ch.red   <= px[2];
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = val;
        else
            cfg_height = val;
    endtask

    task automatic set_dims(input int unsigned w, input int unsigned h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    endtask

    function automatic rgb_t make_pixel(input fill_t fill, input rgb_t flat);
        rgb_t px;
        px = rgb_t'($urandom);
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            case (fill)
                FILL_EXTREME: px[ch] = $urandom_range(1) ? 8'hff : 8'h00;
                FILL_FLAT:    px[ch] = flat[ch];
                FILL_BRIGHT:  px[ch] = CH_W'($urandom_range(255, 230));
                default:      px[ch] = px[ch];
            endcase
        end
        return px;
    endfunction

    task automatic send_frame(input fill_t fill, input rgb_t flat);
        int unsigned n;
        n = eff_width() * eff_height();
        repeat (n) send_pixel(make_pixel(fill, flat));
    endtask

    // only called while idle, so the position is settled
    task automatic finish_frame();
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        w = eff_width();
        h = eff_height();
        r = next_row;
        c = next_col;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;
        if (r != 0 || c != 0)
            repeat ((h - 1 - r) * w + (w - c)) send_pixel(rgb_t'($urandom));
        else if (next_row != 0 || next_col != 0)
            repeat (h * w) send_pixel(rgb_t'($urandom));
    endtask

    task automatic test_reset_geometry();
        send_pixel({8'h00, 8'h00, 8'h00});
        send_pixel({8'hff, 8'hff, 8'hff});
        send_pixel({8'h00, 8'h00, 8'hff});
        send_pixel({8'h00, 8'hff, 8'h00});
        send_pixel({8'hff, 8'h00, 8'h00});
    endtask

    // column past the new width wraps to the next row, row past the new height to row 0
    task automatic test_dims_changed_mid_frame();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 12'd2);
        repeat (3) send_pixel(rgb_t'($urandom));
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 12'd2);
        finish_frame();
    endtask

    task automatic test_zero_dims();
        set_dims(0, 0);
        repeat (3) send_pixel(rgb_t'($urandom));
    endtask

    task automatic test_single_interior();
        set_dims(3, 3);
        send_frame(FILL_FLAT, {8'hff, 8'hff, 8'hff});
        send_frame(FILL_FLAT, {8'h00, 8'h00, 8'h00});
        send_frame(FILL_EXTREME, '0);
        send_frame(FILL_BRIGHT, '0);
    endtask

    task automatic test_thin_images();
        set_dims(2, 5);
        send_frame(FILL_RANDOM, '0);
        set_dims(5, 2);
        send_frame(FILL_RANDOM, '0);
        set_dims(4, 1);
        send_frame(FILL_RANDOM, '0);
        set_dims(3, 4);
        send_frame(FILL_RANDOM, '0);
    endtask

    // start of a maximum-width row and of an over-range width, then realign
    task automatic test_widest_row();
        set_dims(2048, 3);
        repeat (24) send_pixel(rgb_t'($urandom));
        set_dims(4095, 3);
        repeat (24) send_pixel(rgb_t'($urandom));
        set_dims(1, 1);
        finish_frame();
    endtask

    task automatic test_tallest_column();
        set_dims(1, 4095);
        repeat (24) send_pixel(rgb_t'($urandom));
        set_dims(1, 1);
        finish_frame();
    endtask

    task automatic test_random_frames(input int unsigned n_items, input int gap_pct,
                                      input int stall_pct);
        int unsigned start;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned cut;
        bit          need_cfg;
        fill_t       fill;
        pix_gap_pct   = gap_pct;
        res_stall_pct = stall_pct;
        start    = pixels_sent;
        need_cfg = 1'b1;
        while (pixels_sent - start < n_items)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
            begin
                w = $urandom_range(2, 1);
                h = $urandom_range(6, 1);
            end
            else if (sel < 15)
            begin
                w = $urandom_range(9, 3);
                h = $urandom_range(2, 1);
            end
            else if (sel < 25)
            begin
                w = $urandom_range(48, 20);
                h = $urandom_range(4, 3);
            end
            else
            begin
                w = $urandom_range(10, 3);
                h = $urandom_range(7, 3);
            end
            if (need_cfg || $urandom_range(99) < 60)
                set_dims(w, h);
            need_cfg = 1'b0;
            fill = fill_t'($urandom_range(3));
            if ($urandom_range(99) < 10)
            begin
                // cut the frame short, then realign under a pass-through geometry
                cut = $urandom_range(eff_width() * eff_height(), 1);
                repeat (cut) send_pixel(make_pixel(fill, rgb_t'($urandom)));
                set_dims($urandom_range(2, 1), $urandom_range(5, 1));
                finish_frame();
                need_cfg = 1'b1;
            end
            else
                send_frame(fill, rgb_t'($urandom));
        end
    endtask

    initial
    begin
        pixels_sent   = 0;
        pix_gap_pct   = 19;
        res_stall_pct = 60;
        cfg_width     = RESET_WIDTH;
        cfg_height    = RESET_HEIGHT;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_IMAGE_WIDTH;
        cfg_data        <= '0;
        pixel_ch.valid  <= 1'b0;
        pixel_ch.blue   <= '0;
        pixel_ch.green  <= '0;
        pixel_ch.red    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_dims_changed_mid_frame();
        test_zero_dims();
        test_single_interior();
        test_thin_images();
        test_widest_row();
        test_tallest_column();
        test_random_frames(550, 19, 60);
        test_random_frames(550, 60, 19);
        test_random_frames(550, 0, 0);

        wait_idle();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
rtl/boxf_pkg.sv
rtl/boxf_channels.sv
rtl/boxf_ram.sv
rtl/boxf_lane.sv
rtl/boxf_merge.sv
rtl/box_filter_3x3_rgb.sv
rtl/boxf_checker.sv
verif/testbench.sv
